>>> rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on clk, held off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, held off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sss_pkg.sv
// constants and event rom for the shutter signal sequencer
package sss_pkg;

    localparam int TIMEBASE_DIV = 10;
    localparam int ROM_SLOTS    = 8;
    localparam int ROM_IDX_W    = 3;
    localparam int IDX_W        = 4;
    localparam int LEN_W        = 5;
    localparam int CFG_W        = 16;
    localparam int LINE_CNT     = 5;
    localparam int LINE_IDX_W   = 3;

    typedef logic [1:0]            phase_t;
    typedef logic [1:0]            mode_t;
    typedef logic [CFG_W-1:0]      time_t;
    typedef logic [LINE_IDX_W-1:0] line_idx_t;
    typedef logic [LINE_CNT-1:0]   lines_t;

    localparam phase_t PH_IDLE  = 2'd0;
    localparam phase_t PH_OPEN  = 2'd1;
    localparam phase_t PH_LONG  = 2'd2;
    localparam phase_t PH_SHORT = 2'd3;

    localparam mode_t MODE_TICK = 2'd0;
    localparam mode_t MODE_RISE = 2'd1;
    localparam mode_t MODE_FALL = 2'd2;

    localparam line_idx_t L1  = 3'd0;
    localparam line_idx_t L8  = 3'd1;
    localparam line_idx_t L9  = 3'd2;
    localparam line_idx_t L10 = 3'd3;
    localparam line_idx_t L12 = 3'd4;

    localparam lines_t LINES_RESET = lines_t'(1 << L9);

    localparam time_t WIN_START_RESET = time_t'(72000 / TIMEBASE_DIV);
    localparam time_t WIN_END_RESET   = time_t'(130000 / TIMEBASE_DIV);

    // rows: open, close long, close short, unused
    localparam time_t ROM_TIME [4][ROM_SLOTS] = '{
        '{time_t'(25850 / TIMEBASE_DIV), time_t'(34000 / TIMEBASE_DIV),
          time_t'(35100 / TIMEBASE_DIV), time_t'(39400 / TIMEBASE_DIV),
          time_t'(42000 / TIMEBASE_DIV), time_t'(62900 / TIMEBASE_DIV),
          time_t'(71400 / TIMEBASE_DIV), time_t'(0)},
        '{time_t'(200 / TIMEBASE_DIV),    time_t'(5900 / TIMEBASE_DIV),
          time_t'(7200 / TIMEBASE_DIV),   time_t'(8600 / TIMEBASE_DIV),
          time_t'(34800 / TIMEBASE_DIV),  time_t'(71100 / TIMEBASE_DIV),
          time_t'(107600 / TIMEBASE_DIV), time_t'(108000 / TIMEBASE_DIV)},
        '{time_t'(2800 / TIMEBASE_DIV),   time_t'(4300 / TIMEBASE_DIV),
          time_t'(5600 / TIMEBASE_DIV),   time_t'(31600 / TIMEBASE_DIV),
          time_t'(67800 / TIMEBASE_DIV),  time_t'(104000 / TIMEBASE_DIV),
          time_t'(105000 / TIMEBASE_DIV), time_t'(0)},
        '{default: time_t'(0)}
    };

    localparam line_idx_t ROM_LINE [4][ROM_SLOTS] = '{
        '{L9, L1, L10, L1, L1, L10, L12, L1},
        '{L1, L1, L1, L1, L12, L8, L8, L9},
        '{L1, L1, L1, L12, L8, L8, L9, L1},
        '{default: L1}
    };

    localparam logic ROM_LEVEL [4][ROM_SLOTS] = '{
        '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
        '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
        '{default: 1'b0}
    };

    localparam logic [LEN_W-1:0] ROM_COUNT [4] = '{5'd7, 5'd8, 5'd7, 5'd0};

endpackage

>>> rtl/shutter_signal_sequencer_top.sv
// shutter signal sequencer: input register, state update, result register
// an accepted word waits in the input register until its result can load the result register
// throughput: one word per cycle while the output side does not stall, set by the single state update stage
// output register and input register each hold one word, so both sides may stall
// reset: idle phase, timebase stopped, line nine high and other lines low
// reset: fault clear, sample window 7200 to 13000 units
module shutter_signal_sequencer_top
    import sss_pkg::*;
#(
    parameter int ELAPSED_WIDTH = 16,
    parameter int TABLE_DEPTH   = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       mode,
    input  logic             second_trigger_level,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             line1_level,
    output logic             line8_level,
    output logic             line9_level,
    output logic             line10_level,
    output logic             line12_level,
    output logic [1:0]       phase_out,
    output logic             fault,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam logic CFG_WIN_START = 1'b0;
    localparam logic CFG_WIN_END   = 1'b1;

    // input stage
    logic  s1_valid_reg;
    mode_t s1_mode_reg;
    logic  s1_trig2_reg;
    logic  s1_fire;
    logic  out_load;

    // sequencer state
    phase_t                   phase_reg, phase_next;
    logic                     active_reg, active_next;
    logic                     running_reg, running_next;
    logic [ELAPSED_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    lines_t                   line_reg, line_next;
    logic                     fault_reg, fault_next;
    time_t                    win_start_reg;
    time_t                    win_end_reg;

    // output stage
    logic   out_valid_reg;
    lines_t out_line_reg;
    phase_t out_phase_reg;
    logic   out_fault_reg;

    // tick helpers
    logic [1:0]               list_sel;
    logic [LEN_W-1:0]         list_len;
    logic [ELAPSED_WIDTH-1:0] elapsed_inc;
    logic [ROM_IDX_W-1:0]     rom_idx;
    logic                     in_window;

    assign out_load = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_load;
    assign in_ready = !s1_valid_reg || out_load;

    assign list_sel    = phase_reg - 2'd1;
    assign list_len    = (32'(ROM_COUNT[list_sel]) < TABLE_DEPTH) ? ROM_COUNT[list_sel]
                                                                  : LEN_W'(TABLE_DEPTH);
    assign elapsed_inc = elapsed_reg + ELAPSED_WIDTH'(1);
    assign rom_idx     = idx_reg[ROM_IDX_W-1:0];

    always_comb
    begin
        phase_next   = phase_reg;
        active_next  = active_reg;
        running_next = running_reg;
        elapsed_next = elapsed_reg;
        idx_next     = idx_reg;
        line_next    = line_reg;
        fault_next   = fault_reg;
        in_window    = 1'b0;

        if (!fault_reg)
        begin
            case (s1_mode_reg)
                MODE_TICK:
                begin
                    if (running_reg)
                    begin
                        elapsed_next = elapsed_inc;
                    end
                    if (running_reg && (elapsed_inc == '0) && active_reg)
                    begin
                        fault_next = 1'b1;
                    end
                    else if (active_reg && (phase_reg != PH_IDLE))
                    begin
                        if ((LEN_W'(idx_reg) < list_len) && (32'(idx_reg) < ROM_SLOTS) &&
                            (32'(elapsed_next) >= 32'(ROM_TIME[list_sel][rom_idx])))
                        begin
                            line_next[ROM_LINE[list_sel][rom_idx]] =
                                ROM_LEVEL[list_sel][rom_idx];
                            idx_next = idx_reg + IDX_W'(1);
                        end
                        in_window = (32'(elapsed_next) >= 32'(win_start_reg)) &&
                                    (32'(elapsed_next) < 32'(win_end_reg));
                        if (phase_reg == PH_OPEN)
                        begin
                            if (in_window && s1_trig2_reg)
                            begin
                                elapsed_next = '0;
                                running_next = 1'b1;
                                phase_next   = PH_SHORT;
                                idx_next     = '0;
                            end
                        end
                        else if (LEN_W'(idx_next) >= list_len)
                        begin
                            running_next = 1'b0;
                            active_next  = 1'b0;
                            phase_next   = PH_IDLE;
                            idx_next     = '0;
                        end
                    end
                end
                MODE_RISE:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        elapsed_next = '0;
                        running_next = 1'b1;
                        active_next  = 1'b1;
                        phase_next   = PH_OPEN;
                        idx_next     = '0;
                    end
                    else if ((phase_reg == PH_LONG) || (phase_reg == PH_SHORT))
                    begin
                        elapsed_next = '0;
                        running_next = 1'b1;
                        active_next  = 1'b1;
                    end
                end
                MODE_FALL:
                begin
                    if (phase_reg == PH_OPEN)
                    begin
                        line_next[L1] = 1'b0;
                        active_next   = 1'b0;
                        running_next  = 1'b0;
                        phase_next    = PH_LONG;
                        idx_next      = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            active_reg    <= 1'b0;
            running_reg   <= 1'b0;
            elapsed_reg   <= '0;
            idx_reg       <= '0;
            line_reg      <= LINES_RESET;
            fault_reg     <= 1'b0;
            win_start_reg <= WIN_START_RESET;
            win_end_reg   <= WIN_END_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_fire)
            begin
                phase_reg   <= phase_next;
                active_reg  <= active_next;
                running_reg <= running_next;
                elapsed_reg <= elapsed_next;
                idx_reg     <= idx_next;
                line_reg    <= line_next;
                fault_reg   <= fault_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WIN_START: win_start_reg <= cfg_data;
                    CFG_WIN_END:   win_end_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_mode_reg  <= mode;
            s1_trig2_reg <= second_trigger_level;
        end
        if (s1_fire)
        begin
            out_line_reg  <= line_next;
            out_phase_reg <= phase_next;
            out_fault_reg <= fault_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign line1_level  = out_line_reg[L1];
    assign line8_level  = out_line_reg[L8];
    assign line9_level  = out_line_reg[L9];
    assign line10_level = out_line_reg[L10];
    assign line12_level = out_line_reg[L12];
    assign phase_out    = out_phase_reg;
    assign fault        = out_fault_reg;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_fault_sticky, fault_reg, fault_reg, "fault cleared without reset")
    `ASSERT_NEXT(a_fault_freeze, fault_reg, $stable(line_reg) && $stable(phase_reg), "state moved after fault")
    `ASSERT_IMPL(a_idle_quiet, phase_reg == PH_IDLE, !active_reg && !running_reg, "idle phase with timebase active")
    `ASSERT_NEXT(a_hold_no_fire, !s1_fire, $stable(phase_reg) && $stable(idx_reg), "state changed without a word")
    `ASSERT_IMPL(a_idx_bound, 1'b1, 32'(idx_reg) <= ROM_SLOTS, "entry index past rom end")

endmodule

>>> test/sss_checker.sv
// checker for the shutter signal sequencer: tracks config, predicts each result word, compares
module sss_checker
    import sss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [1:0]       mode,
    input  logic             second_trigger_level,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic             line1_level,
    input  logic             line8_level,
    input  logic             line9_level,
    input  logic             line10_level,
    input  logic             line12_level,
    input  logic [1:0]       phase_out,
    input  logic             fault,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REG_WIN_START = 1'b0;
    localparam logic REG_WIN_END   = 1'b1;
    localparam int   SLOTS         = 8;
    localparam int   DEPTH         = 8;

    typedef struct packed {
        lines_t lines;
        phase_t phase;
        logic   fault;
    } shutter_view_t;

    // rows: open, close long, close short; times in 10 us units
    localparam time_t EV_TIME [3][SLOTS] = '{
        '{16'd2585, 16'd3400, 16'd3510, 16'd3940, 16'd4200, 16'd6290, 16'd7140, 16'd0},
        '{16'd20, 16'd590, 16'd720, 16'd860, 16'd3480, 16'd7110, 16'd10760, 16'd10800},
        '{16'd280, 16'd430, 16'd560, 16'd3160, 16'd6780, 16'd10400, 16'd10500, 16'd0}
    };
    localparam line_idx_t EV_LINE [3][SLOTS] = '{
        '{L9, L1, L10, L1, L1, L10, L12, L1},
        '{L1, L1, L1, L1, L12, L8, L8, L9},
        '{L1, L1, L1, L12, L8, L8, L9, L1}
    };
    localparam logic EV_LEVEL [3][SLOTS] = '{
        '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
        '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}
    };
    localparam int EV_COUNT [3] = '{7, 8, 7};

    phase_t        phase_q;
    logic          seq_active;
    logic          timebase_on;
    time_t         elapsed;
    logic [3:0]    entry_pos;
    lines_t        lines_q;
    logic          fault_q;
    time_t         win_start;
    time_t         win_end;
    shutter_view_t predicted_views [$];
    shutter_view_t oldest;

    function automatic void advance_shutter(input mode_t m, input logic trig2);
        int row;
        int len;
        if (fault_q)
            return;
        case (m)
            MODE_TICK:
            begin
                if (timebase_on)
                begin
                    elapsed = elapsed + 16'd1;
                    if (elapsed == '0 && seq_active)
                    begin
                        fault_q = 1'b1;
                        return;
                    end
                end
                if (!seq_active || phase_q == PH_IDLE)
                    return;
                row = int'(phase_q) - 1;
                len = (EV_COUNT[row] < DEPTH) ? EV_COUNT[row] : DEPTH;
                if (entry_pos < len && elapsed >= EV_TIME[row][entry_pos])
                begin
                    lines_q[EV_LINE[row][entry_pos]] = EV_LEVEL[row][entry_pos];
                    entry_pos = entry_pos + 4'd1;
                end
                if (phase_q == PH_OPEN)
                begin
                    if (elapsed >= win_start && elapsed < win_end && trig2)
                    begin
                        elapsed     = '0;
                        timebase_on = 1'b1;
                        phase_q     = PH_SHORT;
                        entry_pos   = '0;
                    end
                end
                else if (entry_pos >= len)
                begin
                    timebase_on = 1'b0;
                    seq_active  = 1'b0;
                    phase_q     = PH_IDLE;
                    entry_pos   = '0;
                end
            end
            MODE_RISE:
            begin
                if (phase_q == PH_IDLE)
                begin
                    elapsed     = '0;
                    timebase_on = 1'b1;
                    seq_active  = 1'b1;
                    phase_q     = PH_OPEN;
                    entry_pos   = '0;
                end
                else if (phase_q == PH_LONG || phase_q == PH_SHORT)
                begin
                    elapsed     = '0;
                    timebase_on = 1'b1;
                    seq_active  = 1'b1;
                end
            end
            MODE_FALL:
            begin
                if (phase_q == PH_OPEN)
                begin
                    lines_q[L1] = 1'b0;
                    seq_active  = 1'b0;
                    timebase_on = 1'b0;
                    phase_q     = PH_LONG;
                    entry_pos   = '0;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_q     = PH_IDLE;
            seq_active  = 1'b0;
            timebase_on = 1'b0;
            elapsed     = '0;
            entry_pos   = '0;
            lines_q     = '0;
            lines_q[L9] = 1'b1;
            fault_q     = 1'b0;
            win_start   = 16'd7200;
            win_end     = 16'd13000;
            predicted_views.delete();
            errors      = 0;
            pending     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WIN_START: win_start = cfg_data;
                    REG_WIN_END:   win_end = cfg_data;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (predicted_views.size() == 0)
                begin
                    $error("result word with no prediction pending");
                    errors++;
                end
                else
                begin
                    oldest = predicted_views.pop_front();
                    compare_field("line1_level", oldest.lines[L1], line1_level);
                    compare_field("line8_level", oldest.lines[L8], line8_level);
                    compare_field("line9_level", oldest.lines[L9], line9_level);
                    compare_field("line10_level", oldest.lines[L10], line10_level);
                    compare_field("line12_level", oldest.lines[L12], line12_level);
                    compare_field("phase_out", oldest.phase, phase_out);
                    compare_field("fault", oldest.fault, fault);
                end
            end
            if (in_valid && in_ready)
            begin
                advance_shutter(mode_t'(mode), second_trigger_level);
                predicted_views.push_back(shutter_view_t'{lines_q, phase_q, fault_q});
            end
            pending = predicted_views.size();
        end
    end

endmodule

>>> test/tb.sv
// testbench top for the shutter signal sequencer: clock, reset, stimulus and verdict
module tb
    import sss_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic  REG_WIN_START = 1'b0;
    localparam logic  REG_WIN_END   = 1'b1;
    localparam mode_t MODE_UNUSED   = 2'd3;
    localparam int    IDLE_PCT      = 26;
    localparam int    STALL_LIMIT   = 1000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [1:0]       mode;
    logic             second_trigger_level;
    logic             out_valid;
    logic             out_ready;
    logic             line1_level;
    logic             line8_level;
    logic             line9_level;
    logic             line10_level;
    logic             line12_level;
    logic [1:0]       phase_out;
    logic             fault;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int   errors;
    int   pending;
    logic no_idle;
    int   quiet_cycles = 0;

    always #5 clk = ~clk;

    shutter_signal_sequencer_top u_top (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .mode                 (mode),
        .second_trigger_level (second_trigger_level),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .line1_level          (line1_level),
        .line8_level          (line8_level),
        .line9_level          (line9_level),
        .line10_level         (line10_level),
        .line12_level         (line12_level),
        .phase_out            (phase_out),
        .fault                (fault),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    sss_checker u_checker (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .mode                 (mode),
        .second_trigger_level (second_trigger_level),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .line1_level          (line1_level),
        .line8_level          (line8_level),
        .line9_level          (line9_level),
        .line10_level         (line10_level),
        .line12_level         (line12_level),
        .phase_out            (phase_out),
        .fault                (fault),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .errors               (errors),
        .pending              (pending)
    );

    always @(negedge clk)
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_word(input mode_t m, input logic trig2);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid             <= 1'b1;
        mode                 <= m;
        second_trigger_level <= trig2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic tick_run(input int n, input int trig2_pct);
        repeat (n)
            send_word(MODE_TICK, $urandom_range(99) < trig2_pct);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_window(input time_t lo, input time_t hi);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_WIN_START;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= REG_WIN_END;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rst_n                = 1'b0;
        in_valid             = 1'b0;
        mode                 = MODE_TICK;
        second_trigger_level = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_WIN_START;
        cfg_data             = '0;
        out_ready            = 1'b0;
        no_idle              = 1'b0;
        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ignored words in idle
        send_word(MODE_TICK, 1'b1);
        send_word(MODE_FALL, 1'b1);
        send_word(MODE_UNUSED, 1'b1);

        // open with a narrow window: below start, exclusive end, inclusive start
        set_window(16'd5, 16'd8);
        send_word(MODE_RISE, 1'b0);
        send_word(MODE_RISE, 1'b1);
        send_word(MODE_UNUSED, 1'b0);
        tick_run(3, 100);
        tick_run(4, 0);
        send_word(MODE_TICK, 1'b1);
        set_window(16'd9, 16'd12);
        send_word(MODE_TICK, 1'b1);

        // short close: fall ignored, rise restarts the counter, early events
        send_word(MODE_FALL, 1'b1);
        send_word(MODE_UNUSED, 1'b1);
        no_idle = 1'b1;
        tick_run(80, 30);
        no_idle = 1'b0;
        send_word(MODE_RISE, 1'b0);
        tick_run(440, 30);
        repeat (20)
            send_word(mode_t'($urandom_range(3)), 1'($urandom_range(1)));

        settle();
        repeat (10)
            @(negedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
